>>> rtl/http_message_parser_top_assert.svh
// Assertion macros shared by the parser modules.
`ifndef HTTP_MESSAGE_PARSER_TOP_ASSERT_SVH
`define HTTP_MESSAGE_PARSER_TOP_ASSERT_SVH

// Condition that holds on every clock edge outside reset.
`define HMP_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define HMP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hmp_pkg.sv
// Shared types, codes and constants of the HTTP message parser.
package hmp_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int QUEUE_DEPTH  = 8;
    localparam int MAX_RESULTS  = 3;

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_HEADERS = 4'b0010,
        PH_BODY    = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    localparam logic [3:0] EV_METHOD  = 4'd0;
    localparam logic [3:0] EV_URL     = 4'd1;
    localparam logic [3:0] EV_VERSION = 4'd2;
    localparam logic [3:0] EV_STATUS  = 4'd3;
    localparam logic [3:0] EV_REASON  = 4'd4;
    localparam logic [3:0] EV_KEY     = 4'd5;
    localparam logic [3:0] EV_VALUE   = 4'd6;
    localparam logic [3:0] EV_HDONE   = 4'd7;
    localparam logic [3:0] EV_FINISH  = 4'd8;
    localparam logic [3:0] EV_ERROR   = 4'd9;

    localparam logic [2:0] ERR_START    = 3'd0;
    localparam logic [2:0] ERR_NO_COLON = 3'd1;
    localparam logic [2:0] ERR_BAD_LEN  = 3'd2;
    localparam logic [2:0] ERR_KEY_EMPTY = 3'd3;
    localparam logic [2:0] ERR_VAL_EMPTY = 3'd4;

    localparam logic [1:0] MT_REQUEST = 2'd0;

    localparam logic       OP_DATA    = 1'b0;
    localparam logic       OP_RESTART = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SP    = 8'h20;

    localparam logic [3:0]  KEY_LEN   = 4'd14;
    localparam logic [3:0]  KEY_FAIL  = 4'd15;
    localparam logic [32:0] LEN_LIMIT = 33'h1_0000_0000;

    // Lower-case "content-length", one character per index.
    function automatic logic [7:0] f_clen_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/hmp_result_fifo.sv
// Result queue: takes up to three results per cycle, hands out one.
module hmp_result_fifo
    import hmp_pkg::*;
#(
    parameter int WIDTH = 72,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  logic [WIDTH-1:0] i_push_data [MAX_RESULTS],
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_room  = (r_count <= CW'(DEPTH - MAX_RESULTS));
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wptr  = r_wptr + AW'(i_push_cnt);
        n_rptr  = r_rptr + AW'(pop);
        n_count = r_count + CW'(i_push_cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < i_push_cnt) begin
                r_mem[r_wptr + AW'(i)] <= i_push_data[i];
            end
        end
    end

    `include "http_message_parser_top_assert.svh"

    `HMP_ASSERT_HOLD(a_count_bound, r_count <= CW'(DEPTH), "result queue overflow")
    `HMP_ASSERT_IMPL(a_push_has_room, i_push_cnt != 2'd0, o_room, "push without room")
    `HMP_ASSERT_NEXT(a_count_track, 1'b1,
        r_count == $past(r_count) + CW'($past(i_push_cnt)) - CW'($past(pop)),
        "queue count mismatch")

endmodule

>>> rtl/hmp_core.sv
// Input register, parser state and per-byte result generation.
module hmp_core
    import hmp_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF,
    parameter int RW       = 2 * POS_BITS + 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_wr_data,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_op,
    input  logic [7:0]    i_byte,
    input  logic          i_room,
    output logic [1:0]    o_push_cnt,
    output logic [RW-1:0] o_push_data [MAX_RESULTS]
);
    localparam int PB = POS_BITS;

    typedef struct packed {
        logic [5:0][PB-1:0] marks;
        logic [2:0]         progress;
        logic               colon;
        logic [3:0]         kmc;
        logic [32:0]        acc;
        logic [1:0]         lflags;
    } t_line;

    logic [1:0]    r_msg_type;
    logic          r_in_valid;
    logic          r_in_op;
    logic [7:0]    r_in_byte;
    logic          consume;

    t_phase        r_phase, n_phase;
    logic [PB-1:0] r_pos, n_pos;
    logic [PB-1:0] r_line_start, n_line_start;
    logic          r_prev_cr, n_prev_cr;
    t_line         r_line, n_line;
    logic [31:0]   r_body_len, n_body_len;
    logic [PB-1:0] r_body_start, n_body_start;

    logic [RW-1:0] res [MAX_RESULTS];
    logic [1:0]    res_cnt;

    function automatic logic [RW-1:0] f_pack(input logic [3:0] kind, input logic [PB-1:0] s,
                                             input logic [PB-1:0] e, input logic [2:0] err,
                                             input logic [31:0] cl);
        return {1'b0, cl, err, e, s, kind};
    endfunction

    function automatic t_line f_line_byte(input t_line s, input logic [7:0] b,
                                          input logic [PB-1:0] q, input logic start);
        t_line       r;
        logic        sp;
        logic [7:0]  lc;
        logic [36:0] prod;
        r    = s;
        sp   = (b == CH_SP);
        lc   = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        prod = '0;
        if (start) begin
            if (r.progress < 3'd5 && sp == r.progress[0]) begin
                for (int i = 0; i < 5; i++) begin
                    if (r.progress == 3'(i)) r.marks[i] = q;
                end
                r.progress = r.progress + 3'd1;
            end
            if (!sp) r.marks[5] = q + PB'(1);
        end else if (!r.colon) begin
            if (b == CH_COLON) begin
                r.colon = 1'b1;
            end else begin
                if (!sp) begin
                    if (!r.progress[0]) begin
                        r.marks[0]    = q;
                        r.progress[0] = 1'b1;
                    end
                    r.marks[1] = q + PB'(1);
                end
                if (r.progress[0]) begin
                    if (r.kmc < KEY_LEN) begin
                        r.kmc = (lc == f_clen_char(r.kmc)) ? r.kmc + 4'd1 : KEY_FAIL;
                    end else if (r.kmc == KEY_LEN && !sp) begin
                        r.kmc = KEY_FAIL;
                    end
                end
            end
        end else begin
            if (!sp) begin
                if (!r.progress[1]) begin
                    r.marks[2]    = q;
                    r.progress[1] = 1'b1;
                end
                r.marks[3] = q + PB'(1);
            end
            if (r.progress[1]) begin
                if (b >= "0" && b <= "9") begin
                    if (r.lflags[0]) begin
                        r.lflags[1] = 1'b1;
                    end else begin
                        // acc*10 + digit, saturating just above 32 bits
                        prod = ({4'b0, r.acc} << 3) + ({4'b0, r.acc} << 1)
                             + {33'b0, b[3:0]};
                        r.acc = (prod > {4'b0, LEN_LIMIT}) ? LEN_LIMIT : prod[32:0];
                    end
                end else if (sp) begin
                    r.lflags[0] = 1'b1;
                end else begin
                    r.lflags[1] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    assign consume = r_in_valid && i_room;
    assign o_ready = i_rst_n && (!r_in_valid || consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_type <= MT_REQUEST;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_msg_type <= i_cfg_wr_data;
            if (o_ready) r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op   <= i_op;
            r_in_byte <= i_byte;
        end
    end

    always_comb begin
        logic [PB-1:0] p;
        logic [PB-1:0] nxt;
        logic [PB-1:0] lend;
        logic [31:0]   bl;
        t_line         s;
        p            = r_pos;
        nxt          = r_pos + PB'(1);
        lend         = r_pos - PB'(1);
        bl           = r_body_len;
        s            = r_line;
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_line_start = r_line_start;
        n_prev_cr    = r_prev_cr;
        n_line       = r_line;
        n_body_len   = r_body_len;
        n_body_start = r_body_start;
        res_cnt      = 2'd0;
        for (int i = 0; i < MAX_RESULTS; i++) res[i] = '0;

        if (consume) begin
            if (r_in_op == OP_RESTART) begin
                n_phase      = PH_START;
                n_pos        = '0;
                n_line_start = '0;
                n_prev_cr    = 1'b0;
                n_line       = '0;
                n_body_len   = '0;
                n_body_start = '0;
            end else if (r_phase == PH_DONE) begin
                n_phase = PH_DONE;
            end else if (r_phase == PH_BODY) begin
                n_pos = nxt;
                if (bl != 32'd0) bl = bl - 32'd1;
                n_body_len = bl;
                if (bl == 32'd0) begin
                    n_phase = PH_DONE;
                    res[0]  = f_pack(EV_FINISH, r_body_start, nxt, ERR_START, 32'd0);
                    res_cnt = 2'd1;
                end
            end else if (r_prev_cr && r_in_byte == CH_LF) begin
                n_prev_cr    = 1'b0;
                n_pos        = nxt;
                n_line_start = nxt;
                n_line       = '0;
                if (r_phase == PH_START) begin
                    if (r_line.progress < 3'd5) begin
                        res[0]  = f_pack(EV_ERROR, r_line_start, lend, ERR_START, 32'd0);
                        res_cnt = 2'd1;
                    end else begin
                        if (r_msg_type == MT_REQUEST) begin
                            res[0] = f_pack(EV_METHOD, r_line.marks[0], r_line.marks[1],
                                            ERR_START, 32'd0);
                            res[1] = f_pack(EV_URL, r_line.marks[2], r_line.marks[3],
                                            ERR_START, 32'd0);
                            res[2] = f_pack(EV_VERSION, r_line.marks[4], r_line.marks[5],
                                            ERR_START, 32'd0);
                        end else begin
                            res[0] = f_pack(EV_VERSION, r_line.marks[0], r_line.marks[1],
                                            ERR_START, 32'd0);
                            res[1] = f_pack(EV_STATUS, r_line.marks[2], r_line.marks[3],
                                            ERR_START, 32'd0);
                            res[2] = f_pack(EV_REASON, r_line.marks[4], r_line.marks[5],
                                            ERR_START, 32'd0);
                        end
                        res_cnt = 2'd3;
                        n_phase = PH_HEADERS;
                    end
                end else if (lend == r_line_start) begin
                    res[0] = f_pack(EV_HDONE, r_line_start, lend, ERR_START, r_body_len);
                    if (r_body_len != 32'd0) begin
                        n_phase      = PH_BODY;
                        n_body_start = nxt;
                        res_cnt      = 2'd1;
                    end else begin
                        n_phase = PH_DONE;
                        res[1]  = f_pack(EV_FINISH, nxt, nxt, ERR_START, 32'd0);
                        res_cnt = 2'd2;
                    end
                end else if (!r_line.colon) begin
                    res[0]  = f_pack(EV_ERROR, r_line_start, lend, ERR_NO_COLON, 32'd0);
                    res_cnt = 2'd1;
                end else if (!r_line.progress[0]) begin
                    res[0]  = f_pack(EV_ERROR, r_line_start, lend, ERR_KEY_EMPTY, 32'd0);
                    res_cnt = 2'd1;
                end else if (!r_line.progress[1]) begin
                    res[0]  = f_pack(EV_ERROR, r_line_start, lend, ERR_VAL_EMPTY, 32'd0);
                    res_cnt = 2'd1;
                end else begin
                    if (r_line.kmc == KEY_LEN &&
                        (r_line.lflags[1] || r_line.acc >= LEN_LIMIT)) begin
                        n_body_len = 32'd0;
                        res[0]  = f_pack(EV_ERROR, r_line_start, lend, ERR_BAD_LEN, 32'd0);
                        res[1]  = f_pack(EV_KEY, r_line.marks[0], r_line.marks[1],
                                         ERR_START, 32'd0);
                        res[2]  = f_pack(EV_VALUE, r_line.marks[2], r_line.marks[3],
                                         ERR_START, 32'd0);
                        res_cnt = 2'd3;
                    end else begin
                        if (r_line.kmc == KEY_LEN) n_body_len = r_line.acc[31:0];
                        res[0]  = f_pack(EV_KEY, r_line.marks[0], r_line.marks[1],
                                         ERR_START, 32'd0);
                        res[1]  = f_pack(EV_VALUE, r_line.marks[2], r_line.marks[3],
                                         ERR_START, 32'd0);
                        res_cnt = 2'd2;
                    end
                end
            end else begin
                // a CR held back from the last byte turns out to be ordinary
                if (r_prev_cr) s = f_line_byte(s, CH_CR, lend, r_phase == PH_START);
                n_prev_cr = (r_in_byte == CH_CR);
                if (r_in_byte != CH_CR) s = f_line_byte(s, r_in_byte, p, r_phase == PH_START);
                n_line = s;
                n_pos  = nxt;
            end
        end

        if (res_cnt != 2'd0) res[res_cnt - 2'd1][RW-1] = 1'b1;
    end

    assign o_push_cnt  = res_cnt;
    assign o_push_data = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_pos        <= '0;
            r_line_start <= '0;
            r_prev_cr    <= 1'b0;
            r_line       <= '0;
            r_body_len   <= '0;
            r_body_start <= '0;
        end else begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_line_start <= n_line_start;
            r_prev_cr    <= n_prev_cr;
            r_line       <= n_line;
            r_body_len   <= n_body_len;
            r_body_start <= n_body_start;
        end
    end

    `include "http_message_parser_top_assert.svh"

    `HMP_ASSERT_NEXT(a_restart_clears, consume && r_in_op == OP_RESTART,
        r_phase == PH_START && r_pos == '0 && !r_prev_cr, "restart did not clear state")
    `HMP_ASSERT_NEXT(a_done_holds, consume && r_in_op == OP_DATA && r_phase == PH_DONE,
        $stable(r_pos) && r_phase == PH_DONE, "finished message moved")
    `HMP_ASSERT_IMPL(a_push_needs_item, res_cnt != 2'd0, consume, "result without item")

endmodule

>>> rtl/http_message_parser_top.sv
// Top level of the HTTP/1.1 message parser.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-----------------------------------------
//  s_       | in  | s_tvalid/s_tready | tdata: data_byte; tuser: operation
//  m_       | out | m_tvalid/m_tready | tdata: span_start,span_end,error_kind,
//           |     |                   |   content_length; tuser: event_kind; tlast
//  cfg      | in  | i_cfg_wr_en       | i_cfg_wr_data: message_type
//
//  One byte per cycle while the queue has room; a byte's results go from the input register into the queue.
//  Line ends may queue up to three results; the 8-entry result queue accepts a byte
//  only with three free slots. With m_tready held high it never gets that full.
//  Reset is synchronous, s_tready is low during it; no clearing pass.
//  A stalled m_ side fills the queue, then stalls s_.
module http_message_parser_top
    import hmp_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // from bit 0: span_start, span_end, error_kind[2:0], content_length[31:0], zero fill
    output logic [((2*POS_BITS+35+7)/8)*8-1:0] m_tdata,
    output logic [3:0]           m_tuser,   // [3:0] event_kind
    output logic                 m_tlast
);
    localparam int PB  = POS_BITS;
    localparam int RW  = 2 * PB + 40;
    localparam int DW  = 2 * PB + 35;
    localparam int TDW = ((DW + 7) / 8) * 8;

    logic          room;
    logic [1:0]    push_cnt;
    logic [RW-1:0] push_data [MAX_RESULTS];
    logic [RW-1:0] head;

    hmp_core #(
        .POS_BITS (PB),
        .RW       (RW)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_tvalid),
        .o_ready       (s_tready),
        .i_op          (s_tuser),
        .i_byte        (s_tdata),
        .i_room        (room),
        .o_push_cnt    (push_cnt),
        .o_push_data   (push_data)
    );

    hmp_result_fifo #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_push_data (push_data),
        .o_room      (room),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_data      (head)
    );

    // queue entry: {last, content_length, error_kind, span_end, span_start, event_kind}
    assign m_tuser = head[3:0];
    assign m_tdata = {{(TDW - DW){1'b0}}, head[RW-2:4]};
    assign m_tlast = head[RW-1];

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the HTTP message parser: directed table, random messages.
module tb_top;
    import hmp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = 16;
    localparam int TDW = ((2*PB+35+7)/8)*8;

    typedef struct {
        logic [3:0]  kind;
        logic [15:0] s;
        logic [15:0] e;
        logic [2:0]  err;
        logic [31:0] cl;
        logic        last;
    } t_event;

    typedef struct {
        logic       op;
        logic [7:0] b;
        bit         chk;
        logic [3:0] kind;
        logic [2:0] err;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [1:0]       i_cfg_wr_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // [7:0] data_byte
    logic             s_tuser;   // [0] operation
    logic             m_tvalid;
    logic             m_tready;
    logic [TDW-1:0]   m_tdata;   // span_start, span_end, error_kind, content_length
    logic [3:0]       m_tuser;   // [3:0] event_kind
    logic             m_tlast;

    http_message_parser_top DUT (.*);

    // parser model state
    logic [1:0]  mtype;
    t_phase      ph;
    logic [15:0] pos, lstart, bstart;
    logic        pcr, colon;
    logic [15:0] marks [6];
    logic [2:0]  prog;
    logic [3:0]  kmatch;
    logic [32:0] acc;
    logic [1:0]  lflags;
    logic [31:0] blen;

    t_event      events_due [$];
    t_event      step_events [$];
    int          errors;
    int          mism;
    int          sent;
    bit          no_idle;
    string       clen_s = "content-length";
    logic [7:0]  msg [$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic void clear_line();
        for (int i = 0; i < 6; i++) marks[i] = '0;
        prog = '0;
        colon = 1'b0;
        kmatch = '0;
        acc = '0;
        lflags = '0;
    endfunction

    function automatic void clear_all();
        ph = PH_START;
        pos = '0;
        lstart = '0;
        pcr = 1'b0;
        blen = '0;
        bstart = '0;
        clear_line();
    endfunction

    function automatic void add_event(logic [3:0] k, logic [15:0] s, logic [15:0] e,
                                      logic [2:0] err, logic [31:0] cl);
        t_event ev;
        ev.kind = k;
        ev.s = s;
        ev.e = e;
        ev.err = err;
        ev.cl = cl;
        ev.last = 1'b0;
        step_events = {step_events, ev};
    endfunction

    function automatic void start_line_byte(logic [7:0] b, logic [15:0] q);
        bit sp;
        sp = (b == CH_SP);
        if (prog < 5 && sp == prog[0]) begin
            marks[prog] = q;
            prog++;
        end
        if (!sp) marks[5] = q + 16'd1;
    endfunction

    function automatic void header_line_byte(logic [7:0] b, logic [15:0] q);
        bit          sp;
        logic [7:0]  lc;
        logic [63:0] t;
        sp = (b == CH_SP);
        if (!colon) begin
            if (b == CH_COLON) begin
                colon = 1'b1;
                return;
            end
            if (!sp) begin
                if (!prog[0]) begin
                    marks[0] = q;
                    prog[0] = 1'b1;
                end
                marks[1] = q + 16'd1;
            end
            if (prog[0]) begin
                if (kmatch < KEY_LEN) begin
                    lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                    kmatch = (lc == clen_s[kmatch]) ? kmatch + 4'd1 : KEY_FAIL;
                end else if (kmatch == KEY_LEN && !sp) begin
                    kmatch = KEY_FAIL;
                end
            end
            return;
        end
        if (!sp) begin
            if (!prog[1]) begin
                marks[2] = q;
                prog[1] = 1'b1;
            end
            marks[3] = q + 16'd1;
        end
        if (prog[1]) begin
            if (b >= "0" && b <= "9") begin
                if (lflags[0]) begin
                    lflags[1] = 1'b1;
                end else begin
                    t = 64'(acc) * 10 + 64'(b - "0");
                    acc = (t > 64'(LEN_LIMIT)) ? LEN_LIMIT : t[32:0];
                end
            end else if (sp) begin
                lflags[0] = 1'b1;
            end else begin
                lflags[1] = 1'b1;
            end
        end
    endfunction

    function automatic void line_byte(logic [7:0] b, logic [15:0] q);
        if (ph == PH_START) start_line_byte(b, q);
        else header_line_byte(b, q);
    endfunction

    function automatic void line_done(logic [15:0] e, logic [15:0] nxt);
        if (ph == PH_START) begin
            if (prog < 5) begin
                add_event(EV_ERROR, lstart, e, ERR_START, '0);
                return;
            end
            if (mtype == MT_REQUEST) begin
                add_event(EV_METHOD, marks[0], marks[1], '0, '0);
                add_event(EV_URL, marks[2], marks[3], '0, '0);
                add_event(EV_VERSION, marks[4], marks[5], '0, '0);
            end else begin
                add_event(EV_VERSION, marks[0], marks[1], '0, '0);
                add_event(EV_STATUS, marks[2], marks[3], '0, '0);
                add_event(EV_REASON, marks[4], marks[5], '0, '0);
            end
            ph = PH_HEADERS;
            return;
        end
        if (e == lstart) begin
            add_event(EV_HDONE, lstart, e, '0, blen);
            if (blen != 0) begin
                ph = PH_BODY;
                bstart = nxt;
            end else begin
                ph = PH_DONE;
                add_event(EV_FINISH, nxt, nxt, '0, '0);
            end
            return;
        end
        if (!colon) begin
            add_event(EV_ERROR, lstart, e, ERR_NO_COLON, '0);
            return;
        end
        if (!prog[0]) begin
            add_event(EV_ERROR, lstart, e, ERR_KEY_EMPTY, '0);
            return;
        end
        if (!prog[1]) begin
            add_event(EV_ERROR, lstart, e, ERR_VAL_EMPTY, '0);
            return;
        end
        if (kmatch == KEY_LEN) begin
            if (!lflags[1] && acc < LEN_LIMIT) begin
                blen = acc[31:0];
            end else begin
                blen = '0;
                add_event(EV_ERROR, lstart, e, ERR_BAD_LEN, '0);
            end
        end
        add_event(EV_KEY, marks[0], marks[1], '0, '0);
        add_event(EV_VALUE, marks[2], marks[3], '0, '0);
    endfunction

    // Advance the model by one accepted byte and queue the events it causes.
    function automatic void parse_step(logic op, logic [7:0] b, bit chk,
                                       logic [3:0] tk, logic [2:0] te);
        logic [15:0] p, nxt;
        p = pos;
        nxt = pos + 16'd1;
        step_events.delete();
        if (op == OP_RESTART) begin
            clear_all();
            return;
        end
        if (ph == PH_DONE) return;
        if (ph == PH_BODY) begin
            pos = nxt;
            if (blen > 0) blen--;
            if (blen == 0) begin
                ph = PH_DONE;
                add_event(EV_FINISH, bstart, nxt, '0, '0);
            end
        end else begin
            if (pcr && b == CH_LF) begin
                pcr = 1'b0;
                line_done(p - 16'd1, nxt);
                lstart = nxt;
                clear_line();
            end else begin
                if (pcr) begin
                    pcr = 1'b0;
                    line_byte(CH_CR, p - 16'd1);
                end
                if (b == CH_CR) pcr = 1'b1;
                else line_byte(b, p);
            end
            pos = nxt;
        end
        if (step_events.size() > 0) begin
            step_events[step_events.size()-1].last = 1'b1;
            if (chk) begin
                step_events[0].kind = tk;
                step_events[0].err = te;
            end
        end
        events_due = {events_due, step_events};
    endfunction

    task automatic send_byte(input logic op, input logic [7:0] b, input bit chk = 0,
                             input logic [3:0] tk = '0, input logic [2:0] te = '0);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        parse_step(op, b, chk, tk, te);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_type(input logic [1:0] v);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mtype = v;
    endtask

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) msg = {msg, s[i]};
    endfunction

    function automatic void put_token(int n, bit letters);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            if (letters) begin
                c = 8'($urandom_range("a", "z"));
            end else begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_SP || c == CH_COLON || c == CH_LF);
            end
            msg = {msg, c};
        end
    endfunction

    function automatic void put_spaces(int lo, int hi);
        repeat ($urandom_range(lo, hi)) msg = {msg, CH_SP};
    endfunction

    function automatic void put_length_value();
        case ($urandom_range(0, 7))
            0: put_str("4294967296");
            1: put_str("99999999999");
            2: put_str("1 2");
            3: put_str("12a");
            4: put_str("0");
            default: put_str($sformatf("%0d", $urandom_range(1, 30)));
        endcase
    endfunction

    // One message: mostly well-formed with random content, sometimes broken.
    task automatic send_message();
        int unsigned nh, blen_s;
        logic [7:0]  nk;
        msg.delete();
        if ($urandom_range(0, 5) == 0) begin
            put_token($urandom_range(0, 4), 0);
            if ($urandom_range(0, 1)) begin
                put_spaces(1, 2);
                put_token($urandom_range(1, 3), 0);
            end
            put_str("\r\n");
        end
        put_spaces(0, 1);
        put_token($urandom_range(1, 5), 0);
        put_spaces(1, 2);
        put_token($urandom_range(1, 5), 0);
        put_spaces(1, 2);
        put_token($urandom_range(1, 3), 0);
        if ($urandom_range(0, 2) == 0) put_str(" x");
        put_spaces(0, 2);
        put_str("\r\n");
        nh = $urandom_range(0, 4);
        for (int h = 0; h < nh; h++) begin
            case ($urandom_range(0, 9))
                0: put_token($urandom_range(1, 5), 1);
                1: begin put_str(":"); put_token(2, 1); end
                2: begin put_token(3, 1); put_str(":"); put_spaces(0, 2); end
                3: begin put_token(3, 1); put_str(":\r"); put_token(2, 1); end
                4, 5, 6: begin
                    put_spaces(0, 1);
                    put_str($urandom_range(0, 1) ? "Content-Length" : "content-LENGTH");
                    put_spaces(0, 1);
                    put_str(":");
                    put_spaces(0, 2);
                    put_length_value();
                    put_spaces(0, 1);
                end
                7: begin put_str("content-len:"); put_token(2, 1); end
                default: begin
                    put_token($urandom_range(1, 6), 1);
                    put_str(":");
                    put_spaces(0, 1);
                    put_token($urandom_range(1, 6), 0);
                end
            endcase
            put_str("\r\n");
        end
        put_str("\r\n");
        blen_s = $urandom_range(0, 32);
        put_token(blen_s, 0);
        send_byte(OP_RESTART, 8'($urandom_range(0, 255)));
        foreach (msg[i]) send_byte(OP_DATA, msg[i]);
    endtask

    t_row rows [$];

    function automatic void add_row(logic op, logic [7:0] b, bit chk = 0,
                                    logic [3:0] k = '0, logic [2:0] e = '0);
        rows = {rows, t_row'{op, b, chk, k, e}};
    endfunction

    // Result side: random stalls per transfer, checks against the oldest due event.
    initial begin
        int unsigned stall;
        t_event      ev;
        logic [3:0]  kind;
        logic [15:0] ss, se;
        logic [2:0]  ek;
        logic [31:0] cl;
        m_tready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            repeat (stall) begin
                m_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_tvalid && i_rst_n)) @(posedge i_clk);
            kind = m_tuser;
            ss = m_tdata[15:0];
            se = m_tdata[31:16];
            ek = m_tdata[34:32];
            cl = m_tdata[66:35];
            if (events_due.size() == 0) begin
                errors++;
                if (mism++ < 10)
                    $display("unexpected transfer: kind %0d span %0d..%0d", kind, ss, se);
            end else begin
                ev = events_due.pop_front();
                if (kind !== ev.kind || ss !== ev.s || se !== ev.e || ek !== ev.err
                    || cl !== ev.cl || m_tlast !== ev.last) begin
                    errors++;
                    if (mism++ < 10) begin
                        $write("mismatch: exp k%0d %0d..%0d e%0d cl%0d l%0d, ",
                               ev.kind, ev.s, ev.e, ev.err, ev.cl, ev.last);
                        $display("got k%0d %0d..%0d e%0d cl%0d l%0d",
                                 kind, ss, se, ek, cl, m_tlast);
                    end
                end
            end
        end
    end

    initial begin
        logic [1:0] types [4] = '{2'd1, 2'd2, 2'd3, 2'd0};
        int         goal;
        errors = 0;
        mism = 0;
        sent = 0;
        no_idle = 0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_DATA;
        mtype = MT_REQUEST;
        clear_all();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty start line, good request line, empty key, line without colon, then end of headers
        add_row(OP_DATA, CH_CR);
        add_row(OP_DATA, CH_LF, 1, EV_ERROR, ERR_START);
        add_row(OP_DATA, 8'hFF);
        add_row(OP_DATA, CH_SP);
        add_row(OP_DATA, 8'h00);
        add_row(OP_DATA, CH_SP);
        add_row(OP_DATA, CH_CR);
        add_row(OP_DATA, "c");
        add_row(OP_DATA, CH_CR);
        add_row(OP_DATA, CH_LF, 1, EV_METHOD, ERR_START);
        add_row(OP_DATA, CH_COLON);
        add_row(OP_DATA, "x");
        add_row(OP_DATA, CH_CR);
        add_row(OP_DATA, CH_LF, 1, EV_ERROR, ERR_KEY_EMPTY);
        add_row(OP_DATA, "k");
        add_row(OP_DATA, CH_CR);
        add_row(OP_DATA, CH_LF, 1, EV_ERROR, ERR_NO_COLON);
        add_row(OP_DATA, CH_CR);
        add_row(OP_DATA, CH_LF, 1, EV_HDONE, ERR_START);
        add_row(OP_DATA, "z");
        add_row(OP_RESTART, 8'h00);
        foreach (rows[i]) send_byte(rows[i].op, rows[i].b, rows[i].chk, rows[i].kind,
                                    rows[i].err);

        goal = sent;
        foreach (types[t]) begin
            write_type(types[t]);
            no_idle = (t == 2);
            goal += 52;
            do begin
                send_message();
                // hold off until everything in flight has come out
                if ($urandom_range(0, 3) == 0) begin
                    s_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (events_due.size() != 0) @(posedge i_clk);
                end
            end while (sent < goal);
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && events_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/hmp_pkg.sv
rtl/hmp_result_fifo.sv
rtl/hmp_core.sv
rtl/http_message_parser_top.sv
tb/tb_top.sv
